[rtl/core/tts_pkg.sv]
// ============================================================================
// tts_pkg
// Shared types and character codes for the text terminal screen buffer.
// ============================================================================
`default_nettype none

package tts_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_BLANK
    } tts_state_t;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] COL_MAX  = 8'hFF;

    localparam logic [6:0] CELL_BLANK = 7'h20;

endpackage : tts_pkg

`default_nettype wire

[rtl/core/text_terminal_screen_buffer.sv]
// ============================================================================
// text_terminal_screen_buffer
// Character-cell terminal screen: cursor control, scrolling, cell readback.
//
//   channel | dir | handshake             | payload
//   cmd     | in  | cmd_valid / cmd_ready | kind, byte_in, read_row, read_col
//   rsp     | out | rsp_valid / rsp_ready | cell_char, cell_is_cursor,
//           |     |                       | cur_row, cur_col
//
// Byte words: the response is registered in the next cycle; line feed at the
// bottom row then blanks one row through the single cell write port. Form
// feed sweeps the whole screen. Read words: the registered cell memory read
// port gives the cell, then the response register takes it in ST_READ.
// After reset the same full-screen sweep runs before cmd_ready rises.
// A stalled response holds cmd_ready low until it is taken.
// ============================================================================
`default_nettype none

module text_terminal_screen_buffer
    import tts_pkg::*;
#(
    parameter int SCREEN_ROWS = 8,
    parameter int SCREEN_COLS = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cmd_valid,
    output logic            cmd_ready,
    input  wire logic       kind,
    input  wire logic [7:0] byte_in,
    input  wire logic [2:0] read_row,
    input  wire logic [4:0] read_col,

    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output logic [6:0]      cell_char,
    output logic            cell_is_cursor,
    output logic [2:0]      cur_row,
    output logic [7:0]      cur_col
);

    localparam int RW     = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int CW     = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
    localparam int MEM_AW = RW + CW;
    localparam int DEPTH  = 1 << MEM_AW;

    localparam logic [RW-1:0] ROW_LAST = RW'(SCREEN_ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(SCREEN_COLS - 1);

    tts_state_t state_reg, state_next;

    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [7:0]        cur_col_reg, cur_col_next;
    logic [RW-1:0]     top_reg, top_next;
    logic [RW-1:0]     sweep_row_reg, sweep_row_next;
    logic [CW-1:0]     sweep_col_reg, sweep_col_next;

    logic              rsp_valid_reg;
    logic [6:0]        cell_char_reg;
    logic              cell_is_cursor_reg;
    logic              rd_hit_reg;
    logic              rd_cur_reg;

    logic [6:0]        cell_mem [DEPTH];
    logic [6:0]        rd_data_reg;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [6:0]        wr_data;
    logic [MEM_AW-1:0] rd_addr;

    logic              accept;
    logic              rd_hit;
    logic              rd_cur;
    logic              printable;
    logic              col_on_screen;
    logic              scroll;

    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] row);
        logic [RW:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (sum >= (RW+1)'(SCREEN_ROWS))
            sum = sum - (RW+1)'(SCREEN_ROWS);
        return sum[RW-1:0];
    endfunction

    assign accept        = cmd_valid && cmd_ready;
    assign printable     = (byte_in >= CH_SPACE) && (byte_in <= CH_TILDE);
    assign col_on_screen = 32'(cur_col_reg) < SCREEN_COLS;
    assign scroll        = (byte_in == CH_LF) && (cur_row_reg == ROW_LAST);
    assign rd_hit        = (32'(read_row) < SCREEN_ROWS) && (32'(read_col) < SCREEN_COLS);
    assign rd_cur        = rd_hit && (32'(read_row) == 32'(cur_row_reg))
                           && (32'(read_col) == 32'(cur_col_reg));
    assign rd_addr       = {phys_row(top_reg, RW'(read_row)), CW'(read_col)};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_col_reg == COL_LAST && sweep_row_reg == ROW_LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind)
                        state_next = ST_READ;
                    else if (byte_in == CH_FF)
                        state_next = ST_CLEAR;
                    else if (scroll)
                        state_next = ST_BLANK;
                end
            end
            ST_READ:
                state_next = ST_IDLE;
            ST_BLANK:
            begin
                if (sweep_col_reg == COL_LAST)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and memory write port
    always_comb
    begin
        cmd_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
        wr_en     = 1'b0;
        wr_addr   = {sweep_row_reg, sweep_col_reg};
        wr_data   = CELL_BLANK;
        case (state_reg)
            ST_CLEAR, ST_BLANK:
                wr_en = 1'b1;
            ST_IDLE:
            begin
                if (accept && !kind && printable && col_on_screen)
                begin
                    wr_en   = 1'b1;
                    wr_addr = {phys_row(top_reg, cur_row_reg), CW'(cur_col_reg)};
                    wr_data = byte_in[6:0];
                end
            end
            default:
                wr_en = 1'b0;
        endcase
    end

    // cursor, scroll offset and sweep counters
    always_comb
    begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        top_next       = top_reg;
        sweep_row_next = sweep_row_reg;
        sweep_col_next = sweep_col_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_col_reg == COL_LAST)
                begin
                    sweep_col_next = '0;
                    sweep_row_next = (sweep_row_reg == ROW_LAST) ? '0 : sweep_row_reg + 1'b1;
                end
                else
                    sweep_col_next = sweep_col_reg + 1'b1;
            end
            ST_BLANK:
                sweep_col_next = (sweep_col_reg == COL_LAST) ? '0 : sweep_col_reg + 1'b1;
            ST_IDLE:
            begin
                if (accept && !kind)
                begin
                    if (byte_in == CH_CR)
                        cur_col_next = '0;
                    else if (byte_in == CH_LF)
                    begin
                        cur_col_next = '0;
                        if (scroll)
                        begin
                            sweep_row_next = top_reg;
                            sweep_col_next = '0;
                            top_next = (top_reg == ROW_LAST) ? '0 : top_reg + 1'b1;
                        end
                        else
                            cur_row_next = cur_row_reg + 1'b1;
                    end
                    else if (byte_in == CH_BS)
                    begin
                        if (cur_col_reg != '0)
                            cur_col_next = cur_col_reg - 1'b1;
                    end
                    else if (byte_in == CH_FF)
                    begin
                        cur_row_next   = '0;
                        cur_col_next   = '0;
                        top_next       = '0;
                        sweep_row_next = '0;
                        sweep_col_next = '0;
                    end
                    else if (printable && cur_col_reg != COL_MAX)
                        cur_col_next = cur_col_reg + 1'b1;
                end
            end
            default:
                sweep_col_next = sweep_col_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            top_reg       <= '0;
            sweep_row_reg <= '0;
            sweep_col_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            top_reg       <= top_next;
            sweep_row_reg <= sweep_row_next;
            sweep_col_reg <= sweep_col_next;
            if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            if ((accept && !kind) || state_reg == ST_READ)
                rsp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_hit_reg <= rd_hit;
            rd_cur_reg <= rd_cur;
            if (!kind)
            begin
                cell_char_reg      <= '0;
                cell_is_cursor_reg <= 1'b0;
            end
        end
        if (state_reg == ST_READ)
        begin
            cell_char_reg      <= rd_hit_reg ? rd_data_reg : '0;
            cell_is_cursor_reg <= rd_cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            cell_mem[wr_addr] <= wr_data;
        rd_data_reg <= cell_mem[rd_addr];
    end

    assign rsp_valid      = rsp_valid_reg;
    assign cell_char      = cell_char_reg;
    assign cell_is_cursor = cell_is_cursor_reg;
    assign cur_row        = 3'(cur_row_reg);
    assign cur_col        = cur_col_reg;

    a_byte_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !kind) |=> rsp_valid_reg)
        else $error("byte word without response");

    a_read_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind) |=> ##1 rsp_valid_reg)
        else $error("read word without response");

    a_ff_home: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !kind && byte_in == CH_FF) |=>
            (cur_row_reg == '0 && cur_col_reg == '0 && state_reg == ST_CLEAR))
        else $error("form feed did not home and clear");

    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(top_reg) < SCREEN_ROWS) && (32'(cur_row_reg) < SCREEN_ROWS))
        else $error("row register out of range");

endmodule : text_terminal_screen_buffer

`default_nettype wire

[verif/tb_text_terminal_screen_buffer.sv]
// ============================================================================
// tb_text_terminal_screen_buffer
// Self-checking bench for the text terminal screen buffer. Command words
// (terminal bytes and cell reads) go in over valid/ready. A screen tracker
// mirrors the cells, the scroll offset and the cursor, and predicts every
// response. Actual responses are compared against it in order.
// ============================================================================
`default_nettype none

module tb_text_terminal_screen_buffer;
    import tts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_ROWS  = 8;
    localparam int SCREEN_COLS  = 32;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PHASE_WORDS  = 567;
    localparam int LONG_LINE    = 270;
    localparam int TAIL_CYCLES  = 300;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_US  = 8'h1F;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_HI  = 8'h80;
    localparam logic [7:0] CH_TOP = 8'hFF;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_READ = 1'b1
    } word_kind_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       is_cur;
        logic [2:0] row;
        logic [7:0] col;
    } screen_rsp_t;

    class screen_tracker;
        logic [6:0]  cells [SCREEN_ROWS][SCREEN_COLS];
        logic [2:0]  top_row;
        logic [2:0]  cur_row;
        logic [7:0]  cur_col;
        screen_rsp_t pending_rsps [$];
        int          errors;

        function new();
            foreach (cells[r, c])
                cells[r][c] = CELL_BLANK;
            top_row = '0;
            cur_row = '0;
            cur_col = '0;
            errors  = 0;
        endfunction

        function int pending();
            return pending_rsps.size();
        endfunction

        function void note_word(logic k, logic [7:0] b, logic [2:0] rr, logic [4:0] rc);
            screen_rsp_t rsp;
            logic [2:0]  prow;
            rsp = '0;
            if (k == KIND_READ) begin
                prow       = top_row + rr;
                rsp.ch     = cells[prow][rc];
                rsp.is_cur = (rr == cur_row) && ({3'b000, rc} == cur_col);
            end
            else if (b == CH_CR) begin
                cur_col = '0;
            end
            else if (b == CH_LF) begin
                cur_col = '0;
                if (cur_row == 3'(SCREEN_ROWS - 1)) begin
                    for (int c = 0; c < SCREEN_COLS; c++)
                        cells[top_row][c] = CELL_BLANK;
                    top_row = top_row + 3'd1;
                end
                else begin
                    cur_row = cur_row + 3'd1;
                end
            end
            else if (b == CH_BS) begin
                if (cur_col != 0)
                    cur_col = cur_col - 8'd1;
            end
            else if (b == CH_FF) begin
                foreach (cells[r, c])
                    cells[r][c] = CELL_BLANK;
                top_row = '0;
                cur_row = '0;
                cur_col = '0;
            end
            else if (b >= CH_SPACE && b <= CH_TILDE) begin
                prow = top_row + cur_row;
                if (cur_col < SCREEN_COLS)
                    cells[prow][cur_col[4:0]] = b[6:0];
                if (cur_col != COL_MAX)
                    cur_col = cur_col + 8'd1;
            end
            rsp.row = cur_row;
            rsp.col = cur_col;
            pending_rsps.push_back(rsp);
        endfunction

        function void compare_field(string fname, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t mismatch %s: expected %0d actual %0d", $time, fname, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_rsp(logic [6:0] ch, logic is_cur, logic [2:0] row, logic [7:0] col);
            screen_rsp_t exp_rsp;
            if (pending_rsps.size() == 0) begin
                $display("%0t unexpected response: expected none actual ch=%0d cur=%0d row=%0d col=%0d",
                         $time, ch, is_cur, row, col);
                errors++;
                return;
            end
            exp_rsp = pending_rsps.pop_front();
            compare_field("cell_char", exp_rsp.ch, ch);
            compare_field("cell_is_cursor", exp_rsp.is_cur, is_cur);
            compare_field("cur_row", exp_rsp.row, row);
            compare_field("cur_col", exp_rsp.col, col);
        endfunction
    endclass

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cmd_valid      = 1'b0;
    logic       cmd_ready;
    logic       kind           = 1'b0;
    logic [7:0] byte_in        = '0;
    logic [2:0] read_row       = '0;
    logic [4:0] read_col       = '0;
    logic       rsp_valid;
    logic       rsp_ready      = 1'b0;
    logic [6:0] cell_char;
    logic       cell_is_cursor;
    logic [2:0] cur_row;
    logic [7:0] cur_col;

    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    int unsigned   cycles        = 0;
    screen_tracker screen        = new();

    text_terminal_screen_buffer #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .kind           (kind),
        .byte_in        (byte_in),
        .read_row       (read_row),
        .read_col       (read_col),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .cell_char      (cell_char),
        .cell_is_cursor (cell_is_cursor),
        .cur_row        (cur_row),
        .cur_col        (cur_col)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            screen.note_word(kind, byte_in, read_row, read_col);
        if (rsp_valid && rsp_ready)
            screen.check_rsp(cell_char, cell_is_cursor, cur_row, cur_col);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic k, input logic [7:0] b,
                             input logic [2:0] rr, input logic [4:0] rc);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        kind      <= k;
        byte_in   <= b;
        read_row  <= rr;
        read_col  <= rc;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(KIND_BYTE, b, 3'($urandom_range(7)), 5'($urandom_range(31)));
    endtask

    task automatic send_read(input logic [2:0] rr, input logic [4:0] rc);
        send_word(KIND_READ, 8'($urandom_range(255)), rr, rc);
    endtask

    // half of the reads aim at the cursor; past the last column only its row is used
    task automatic send_random_read();
        logic [2:0] rr;
        logic [4:0] rc;
        rr = 3'($urandom_range(7));
        rc = 5'($urandom_range(31));
        if ($urandom_range(1) == 1) begin
            rr = screen.cur_row;
            if (screen.cur_col < SCREEN_COLS)
                rc = screen.cur_col[4:0];
        end
        send_read(rr, rc);
    endtask

    task automatic send_random_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)
            send_random_read();
        else if (pick < 70)
            send_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
        else if (pick < 80)
            send_byte(CH_LF);
        else if (pick < 84)
            send_byte(CH_CR);
        else if (pick < 90)
            send_byte(CH_BS);
        else if (pick < 91)
            send_byte(CH_FF);
        else if (pick < 95)
            send_byte(8'($urandom_range(CH_HI, CH_TOP)));
        else
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (screen.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed
        send_read(3'd0, 5'd0);
        send_byte(8'h41);
        send_byte(CH_TILDE);
        send_byte(CH_SPACE);
        send_byte(CH_US);
        send_byte(CH_DEL);
        send_byte(CH_TOP);
        send_byte(CH_HI);
        send_byte(CH_NUL);
        send_word(KIND_READ, CH_FF, 3'd0, 5'd1);
        repeat (4) send_byte(CH_BS);
        send_byte(CH_CR);
        repeat (8) send_byte(CH_LF);
        send_word(KIND_READ, CH_TOP, 3'd7, 5'd31);
        send_byte(CH_FF);
        send_read(3'd7, 5'd31);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 10; recv_idle_pct = 46; end
                1: begin send_idle_pct = 46; recv_idle_pct = 10; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (phase == 0) begin
                // one long line runs the column past the screen width
                send_byte(CH_CR);
                for (int i = 0; i < LONG_LINE; i++) begin
                    if ($urandom_range(99) < 88)
                        send_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
                    else if ($urandom_range(1) == 1)
                        send_byte(CH_BS);
                    else
                        send_random_read();
                end
            end
            for (int i = 0; i < PHASE_WORDS; i++)
                send_random_word();
            drain();
        end

        while (screen.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (screen.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule : tb_text_terminal_screen_buffer

`default_nettype wire

[filelist.f]
rtl/core/tts_pkg.sv
rtl/core/text_terminal_screen_buffer.sv
verif/tb_text_terminal_screen_buffer.sv
